### sv/bitfield_read_write_store_macros.svh
// Assertion macros used by the checker file bfrws_checker.sv.
`ifndef BITFIELD_READ_WRITE_STORE_MACROS_SVH
`define BITFIELD_READ_WRITE_STORE_MACROS_SVH

// same-cycle implication
`define BFRWS_CHK_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bfrws same-cycle check failed");

// next-cycle implication
`define BFRWS_CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bfrws next-cycle check failed");

`endif

### sv/bfrws_pkg.sv
package bfrws_pkg;

    localparam int STORE_BYTES_DEF    = 256;
    localparam int MAX_FIELD_BITS_DEF = 32;

    localparam int REQ_W  = 2;
    localparam int OFF_W  = 11;
    localparam int WID_W  = 6;
    localparam int DATA_W = 32;
    localparam int ST_W   = 2;

    localparam logic [REQ_W-1:0] REQ_UREAD = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SREAD = 2'd1;
    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd2;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD_WIDTH = 2'd1;
    localparam logic [ST_W-1:0] ST_PAST_END  = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [OFF_W-1:0]  bit_offset;
        logic [WID_W-1:0]  field_width;
        logic [DATA_W-1:0] write_value;
    } t_req;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [ST_W-1:0]   status;
        logic              do_write;
    } t_res;

endpackage

### sv/bfrws_bank.sv
module bfrws_bank #(
    parameter int ROWS  = 32,
    parameter int ROW_W = 5
) (
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [ROW_W-1:0] i_rd_row,
    output logic [7:0]       o_rd_data,
    input  logic             i_wr_en,
    input  logic [ROW_W-1:0] i_wr_row,
    input  logic [7:0]       i_wr_data
);

    logic [7:0] r_mem [ROWS];
    logic [7:0] r_rd_data;

    // read-first: a read and write to the same row in one cycle returns old data
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_row] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_row];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### sv/bfrws_field.sv
module bfrws_field #(
    parameter int STORE_BYTES    = bfrws_pkg::STORE_BYTES_DEF,
    parameter int MAX_FIELD_BITS = bfrws_pkg::MAX_FIELD_BITS_DEF,
    parameter int W              = 64
) (
    input  bfrws_pkg::t_req i_req,
    input  logic [W-1:0]    i_win,
    output bfrws_pkg::t_res o_res,
    output logic [W-1:0]    o_win,
    output logic [W-1:0]    o_mask
);

    localparam int TW = $clog2(W) + 2;

    logic [bfrws_pkg::WID_W-1:0] n;
    logic [2:0]                  s;
    logic [TW-1:0]               t;
    logic [W-1:0]                mask_n;
    logic [W-1:0]                fld;
    logic [W-1:0]                ins;
    logic                        bad_width;
    logic                        past_end;
    logic                        sgn;
    logic [bfrws_pkg::DATA_W-1:0] rd;

    always_comb begin
        n = i_req.field_width;
        s = i_req.bit_offset[2:0];
        // distance from field LSB to window LSB; valid whenever the width is legal
        t = TW'(W) - TW'(s) - TW'(n);
        mask_n = ~({W{1'b1}} << n);
        fld = (i_win >> t) & mask_n;
        sgn = (fld & (mask_n ^ (mask_n >> 1))) != '0;

        bad_width = (n == '0) || (32'(n) > 32'(MAX_FIELD_BITS));
        past_end  = (32'(i_req.bit_offset) + 32'(n)) > 32'(STORE_BYTES * 8);

        rd = 32'(fld);
        if (i_req.req_type == bfrws_pkg::REQ_SREAD && n < 6'd32 && sgn) begin
            rd = rd | ~32'(mask_n);
        end

        ins    = (W'(i_req.write_value) & mask_n) << t;
        o_mask = mask_n << t;
        o_win  = (i_win & ~o_mask) | ins;

        o_res.do_write  = 1'b0;
        o_res.read_data = '0;
        priority if (bad_width) begin
            o_res.status = bfrws_pkg::ST_BAD_WIDTH;
        end else if (past_end) begin
            o_res.status = bfrws_pkg::ST_PAST_END;
        end else if (i_req.req_type == bfrws_pkg::REQ_WRITE) begin
            o_res.status   = bfrws_pkg::ST_OK;
            o_res.do_write = 1'b1;
        end else begin
            o_res.status    = bfrws_pkg::ST_OK;
            o_res.read_data = rd;
        end
    end

endmodule

### sv/bitfield_read_write_store.sv
// MSB-first bit-field store. Each request extracts or inserts a field of 1 to
// MAX_FIELD_BITS bits at any bit offset; bit k is bit 7-(k mod 8) of byte k/8.
// The store is split into NB byte-wide banks (8 with default parameters) so
// every byte a field can touch is read at once; the read-modify-write is
// done in the next stage and a one-deep bypass per bank covers a request
// that reads what the previous one writes. One request is taken per cycle
// while o_stall is low; its result passes through the bank read register and
// then the result register, and is held there while i_stall is high. After
// reset the store is cleared row by row with o_stall high.
module bitfield_read_write_store #(
    parameter int STORE_BYTES    = bfrws_pkg::STORE_BYTES_DEF,
    parameter int MAX_FIELD_BITS = bfrws_pkg::MAX_FIELD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [bfrws_pkg::REQ_W-1:0]   i_req_type,
    input  logic [bfrws_pkg::OFF_W-1:0]   i_bit_offset,
    input  logic [bfrws_pkg::WID_W-1:0]   i_field_width,
    input  logic [bfrws_pkg::DATA_W-1:0]  i_write_value,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [bfrws_pkg::DATA_W-1:0]  o_read_data,
    output logic [bfrws_pkg::ST_W-1:0]    o_status
);

    localparam int NB    = 2 ** $clog2((MAX_FIELD_BITS + 14) / 8);
    localparam int LB    = $clog2(NB);
    localparam int W     = NB * 8;
    localparam int ROWS  = (STORE_BYTES + NB - 1) / NB;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic                 r_clr_busy;
    logic [ROW_W-1:0]     r_clr_row;
    logic                 r_s1_valid;
    bfrws_pkg::t_req      r_s1_req;
    logic                 r_o_valid;
    logic [bfrws_pkg::DATA_W-1:0] r_o_read_data;
    logic [bfrws_pkg::ST_W-1:0]   r_o_status;
    logic [NB-1:0]        r_byp_vld;
    logic [ROW_W-1:0]     r_byp_row  [NB];
    logic [7:0]           r_byp_data [NB];

    logic                 in_acc;
    logic                 s1_adv;
    logic [LB-1:0]        in_lo;
    logic [ROW_W-1:0]     in_row0;
    logic [LB-1:0]        s1_lo;
    logic [ROW_W-1:0]     s1_row0;
    logic [ROW_W-1:0]     in_row [NB];
    logic [ROW_W-1:0]     s1_row [NB];
    logic [7:0]           bank_rd [NB];
    logic [7:0]           fwd [NB];
    logic [NB-1:0]        wen;
    logic [ROW_W-1:0]     wrow  [NB];
    logic [7:0]           wdata [NB];
    logic [W-1:0]         s1_win;
    logic [W-1:0]         s1_new;
    logic [W-1:0]         s1_mask;
    bfrws_pkg::t_res      s1_res;
    bfrws_pkg::t_req      in_req;

    assign s1_adv  = !r_o_valid || !i_stall;
    assign o_stall = r_clr_busy || (r_s1_valid && !s1_adv);
    assign in_acc  = i_valid && !o_stall;

    assign in_req.req_type    = i_req_type;
    assign in_req.bit_offset  = i_bit_offset;
    assign in_req.field_width = i_field_width;
    assign in_req.write_value = i_write_value;

    assign in_lo   = i_bit_offset[3 +: LB];
    assign in_row0 = ROW_W'(i_bit_offset >> (3 + LB));
    assign s1_lo   = r_s1_req.bit_offset[3 +: LB];
    assign s1_row0 = ROW_W'(r_s1_req.bit_offset >> (3 + LB));

    for (genvar b = 0; b < NB; b++) begin : g_bank
        logic [LB-1:0] kb;

        // banks below the start bank hold bytes of the next row
        assign in_row[b] = (LB'(b) < in_lo) ? in_row0 + ROW_W'(1) : in_row0;
        assign s1_row[b] = (LB'(b) < s1_lo) ? s1_row0 + ROW_W'(1) : s1_row0;

        assign fwd[b] = (r_byp_vld[b] && r_byp_row[b] == s1_row[b]) ?
                        r_byp_data[b] : bank_rd[b];

        assign kb = LB'(b) - s1_lo;

        always_comb begin
            if (r_clr_busy) begin
                wen[b]   = 1'b1;
                wrow[b]  = r_clr_row;
                wdata[b] = '0;
            end else begin
                wen[b]   = r_s1_valid && s1_adv && s1_res.do_write &&
                           (s1_mask[(NB - 1 - int'(kb)) * 8 +: 8] != '0);
                wrow[b]  = s1_row[b];
                wdata[b] = s1_new[(NB - 1 - int'(kb)) * 8 +: 8];
            end
        end

        bfrws_bank #(
            .ROWS  (ROWS),
            .ROW_W (ROW_W)
        ) u_bank (
            .i_clk     (i_clk),
            .i_rd_en   (in_acc),
            .i_rd_row  (in_row[b]),
            .o_rd_data (bank_rd[b]),
            .i_wr_en   (wen[b]),
            .i_wr_row  (wrow[b]),
            .i_wr_data (wdata[b])
        );

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_byp_vld[b] <= 1'b0;
            end else if (wen[b]) begin
                r_byp_vld[b] <= 1'b1;
            end
            if (wen[b]) begin
                r_byp_row[b]  <= wrow[b];
                r_byp_data[b] <= wdata[b];
            end
        end
    end

    // window byte k is store byte (start byte + k), big-endian in the window
    for (genvar k = 0; k < NB; k++) begin : g_win
        assign s1_win[W - 1 - 8 * k -: 8] = fwd[LB'(s1_lo + LB'(k))];
    end

    bfrws_field #(
        .STORE_BYTES    (STORE_BYTES),
        .MAX_FIELD_BITS (MAX_FIELD_BITS),
        .W              (W)
    ) u_field (
        .i_req  (r_s1_req),
        .i_win  (s1_win),
        .o_res  (s1_res),
        .o_win  (s1_new),
        .o_mask (s1_mask)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_row  <= '0;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_row <= r_clr_row + ROW_W'(1);
                if (r_clr_row == ROW_W'(ROWS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end

            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (r_s1_valid && s1_adv) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end

        if (in_acc) begin
            r_s1_req <= in_req;
        end
        if (r_s1_valid && s1_adv) begin
            r_o_read_data <= s1_res.read_data;
            r_o_status    <= s1_res.status;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_read_data = r_o_read_data;
    assign o_status    = r_o_status;

endmodule

### sv/bfrws_checker.sv
`include "bitfield_read_write_store_macros.svh"

module bfrws_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [bfrws_pkg::DATA_W-1:0]  o_read_data,
    input logic [bfrws_pkg::ST_W-1:0]    o_status
);

    logic in_beat;
    logic res_err;
    logic held;

    assign in_beat = i_valid && !o_stall;
    assign res_err = o_valid && (o_status != bfrws_pkg::ST_OK);
    assign held    = o_valid && i_stall;

    // store is being cleared right after reset
    `BFRWS_CHK_SAME(a_clear_after_reset, i_clk, i_rst_n, $rose(i_rst_n), o_stall)

    // a new result beat always traces back to an earlier request beat
    `BFRWS_CHK_SAME(a_out_from_in, i_clk, i_rst_n, $rose(o_valid), $past(in_beat, 2))

    // rejected requests return no data
    `BFRWS_CHK_SAME(a_err_no_data, i_clk, i_rst_n, res_err, o_read_data == '0)

    `BFRWS_CHK_NEXT(a_out_hold, i_clk, i_rst_n, held, o_valid && $stable({o_read_data, o_status}))

endmodule

bind bitfield_read_write_store bfrws_checker u_bfrws_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_read_data   (o_read_data),
    .o_status      (o_status)
);
